@@ sv/follow_goal_generator_unit_defines.svh @@
// Assertion macros shared by the follow goal generator checker
`ifndef FOLLOW_GOAL_GENERATOR_UNIT_DEFINES_SVH
`define FOLLOW_GOAL_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, reset disabled
`define FGG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disabled
`define FGG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/fgg_pkg.sv @@
// Types, constants and helper functions of the follow goal generator
package fgg_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int POS_W      = 24;
    localparam int ANG_W      = 16;
    localparam int QUAT_W     = 16;
    localparam int DIST_W     = 20;
    localparam int PER_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    // shared square root / divide unit
    localparam int SQ_IN_W   = 58;
    localparam int SQ_STEPS  = 29;
    localparam int SD_RES_W  = 29;
    localparam int DV_NUM_W  = 50;
    localparam int DV_DEN_W  = 30;
    localparam int DV_QBITS  = 27;
    localparam int SD_REM_W  = 32;
    localparam int SD_CNT_W  = 5;

    localparam int ACC_W = 60;
    localparam int MUL_W = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOLLOW_DIST = 4'd0,
        REG_INIT_STEP   = 4'd1,
        REG_UPD_THRESH  = 4'd2,
        REG_MIN_PERIOD  = 4'd3
    } t_reg_idx;

    typedef enum logic {
        SD_SQRT,
        SD_DIV
    } t_sd_op;

    typedef struct packed {
        logic   start;
        t_sd_op op;
    } t_sd_ctrl;

    typedef struct packed {
        logic signed [POS_W-1:0]  lead_pos_x;
        logic signed [POS_W-1:0]  lead_pos_y;
        logic signed [QUAT_W-1:0] leader_qx;
        logic signed [QUAT_W-1:0] leader_qy;
        logic signed [QUAT_W-1:0] leader_qz;
        logic signed [QUAT_W-1:0] leader_qw;
        logic signed [POS_W-1:0]  foll_pos_x;
        logic signed [POS_W-1:0]  foll_pos_y;
        logic signed [ANG_W-1:0]  follower_yaw;
        logic        [TIME_W-1:0] now_ms;
        logic                     blocked;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [ANG_W-1:0] start_heading;
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic signed [ANG_W-1:0] goal_heading;
        logic                    send_goal;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE, S_C0, S_C1, S_C2, S_C3, S_S0, S_S1,
        S_R0, S_R1, S_R2, S_R3, S_RW,
        S_TX0, S_TX1, S_TXW, S_TY0, S_TY1, S_TYW,
        S_DIFF, S_COR,
        S_D0, S_D1, S_D2, S_DW,
        S_GX0, S_GX1, S_GXW, S_GY0, S_GY1, S_GYW,
        S_CMP0, S_CMP1, S_CMP2, S_FIN
    } t_state;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [27:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 28'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/fgg_sqdiv.sv @@
// Shared iterative unit: floor square root (2 bits a cycle) or unsigned divide (1 bit a cycle)
module fgg_sqdiv import fgg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_sd_ctrl            i_ctrl,
    input  logic [SQ_IN_W-1:0]  i_a,
    input  logic [DV_DEN_W-1:0] i_b,
    output logic                o_busy,
    output logic [SD_RES_W-1:0] o_res
);

    logic                r_busy;
    t_sd_op              r_op;
    logic [SD_CNT_W-1:0] r_cnt;
    logic [SD_REM_W-1:0] r_rem;
    logic [SQ_IN_W-1:0]  r_w;
    logic [SD_RES_W-1:0] r_res;
    logic [DV_DEN_W-1:0] r_b;

    logic [SD_REM_W+1:0] rem_sh;
    logic [SD_REM_W+1:0] trial;
    logic [SD_REM_W+1:0] diff;
    logic                ge;

    // one compare-subtract serves both operations
    always_comb begin
        if (r_op == SD_SQRT) begin
            rem_sh = {r_rem, r_w[SQ_IN_W-1 -: 2]};
            trial  = (SD_REM_W+2)'({r_res, 2'b01});
        end else begin
            rem_sh = (SD_REM_W+2)'({r_rem, r_w[SQ_IN_W-1]});
            trial  = (SD_REM_W+2)'(r_b);
        end
        ge   = (rem_sh >= trial);
        diff = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= SD_SQRT;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_op   <= i_ctrl.op;
            r_res  <= '0;
            r_b    <= i_b;
            if (i_ctrl.op == SD_SQRT) begin
                r_rem <= '0;
                r_w   <= i_a;
                r_cnt <= SD_CNT_W'(SQ_STEPS);
            end else begin
                r_rem <= SD_REM_W'(i_a[DV_NUM_W-1:DV_QBITS]);
                r_w   <= {i_a[DV_QBITS-1:0], (SQ_IN_W-DV_QBITS)'(0)};
                r_cnt <= SD_CNT_W'(DV_QBITS);
            end
        end else if (r_busy) begin
            r_rem <= ge ? diff[SD_REM_W-1:0] : rem_sh[SD_REM_W-1:0];
            r_w   <= (r_op == SD_SQRT) ? (r_w << 2) : (r_w << 1);
            r_res <= {r_res[SD_RES_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == SD_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

@@ sv/follow_goal_generator_unit.sv @@
// One item at a time: a new transaction is taken only in the idle state. A new result
// waits in S_FIN while the previous one is still stalled at the output.
// A blocked transaction is taken but yields no result.
// Shared multiplier, shared square root / divide unit, 16-step CORDIC.
// Reset (synchronous, active low) clears goal history and sequencer and loads config defaults.
module follow_goal_generator_unit import fgg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // configuration
    logic [DIST_W-1:0] r_fd, r_istep, r_thr;
    logic [PER_W-1:0]  r_minp;

    // goal history
    logic signed [POS_W-1:0] r_pgx, r_pgy, r_sgx, r_sgy;
    logic signed [ANG_W-1:0] r_pgh;
    logic                    r_have_prior, r_have_sent, r_first_done;
    logic [TIME_W-1:0]       r_stime;

    // working registers
    t_in_item                r_in;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [28:0]      r_c;
    logic signed [29:0]      r_s;
    logic [SD_RES_W-1:0]     r_r;
    logic signed [25:0]      r_tx, r_ty, r_dx, r_dy;
    logic [DIST_W-1:0]       r_st;
    logic                    r_neg, r_stepped;
    logic signed [POS_W-1:0] r_gx, r_gy;
    logic signed [ANG_W-1:0] r_gh;
    logic signed [28:0]      r_cx, r_cy;
    logic [31:0]             r_cz;
    logic [4:0]              r_ci;

    logic                    r_out_valid;
    t_out_item               r_out;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic                      acc_clr, acc_sub, acc_en;

    t_sd_ctrl              sd_ctrl;
    logic [SQ_IN_W-1:0]    sd_a;
    logic                  sd_busy;
    logic [SD_RES_W-1:0]   sd_res;

    logic signed [ACC_W-1:0] acc_mag;
    logic signed [29:0]      qs;
    logic signed [29:0]      s_val;
    logic signed [25:0]      dx_c, dy_c;
    logic signed [28:0]      cx_s, cy_s, n_cx, n_cy;
    logic [31:0]             n_cz, gh_round;
    logic                    cor_last, step_en, fin_go, short_move, soon, send;
    logic [TIME_W-1:0]       age;
    logic [DIST_W-1:0]       st_c;
    logic signed [24:0]      ddx, ddy;

    // divisor is the heading norm for the target, the distance for the step limit
    fgg_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sd_ctrl),
        .i_a     (sd_a),
        .i_b     (DV_DEN_W'(r_r)),
        .o_busy  (sd_busy),
        .o_res   (sd_res)
    );

    // datapath helpers
    always_comb begin
        acc_mag  = r_acc[ACC_W-1] ? -r_acc : r_acc;
        qs       = r_neg ? -$signed({1'b0, sd_res}) : $signed({1'b0, sd_res});
        s_val    = r_acc[32:3];
        dx_c     = r_tx - 26'(r_in.foll_pos_x);
        dy_c     = r_ty - 26'(r_in.foll_pos_y);
        cx_s     = r_cx >>> r_ci;
        cy_s     = r_cy >>> r_ci;
        if (r_cy > 29'sd0) begin
            n_cx = r_cx + cy_s;
            n_cy = r_cy - cx_s;
            n_cz = r_cz + atan_turn(r_ci);
        end else begin
            n_cx = r_cx - cy_s;
            n_cy = r_cy + cx_s;
            n_cz = r_cz - atan_turn(r_ci);
        end
        gh_round   = (n_cz + 32'h0000_8000) >> 16;
        cor_last   = (r_ci == 5'(CORDIC_STEPS - 1));
        step_en    = !r_first_done && (r_istep != '0);
        st_c       = (SD_RES_W'(r_istep) < sd_res) ? r_istep : sd_res[DIST_W-1:0];
        ddx        = 25'(r_gx) - 25'(r_sgx);
        ddy        = 25'(r_gy) - 25'(r_sgy);
        fin_go     = !r_out_valid || i_out_ready;
        short_move = r_acc[ACC_W-1];
        age        = r_in.now_ms - r_stime;
        soon       = age < TIME_W'(r_minp);
        send       = !r_have_sent || !(short_move || soon);
    end

    // sequencer: next state, multiplier operands, shared unit control
    always_comb begin
        n_state    = r_state;
        mul_a      = '0;
        mul_b      = '0;
        acc_en     = 1'b0;
        acc_clr    = 1'b0;
        acc_sub    = 1'b0;
        sd_ctrl    = '{start: 1'b0, op: SD_SQRT};
        sd_a       = SQ_IN_W'(r_acc[SQ_IN_W-1:0]);
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_in.blocked) begin
                    n_state = S_C0;
                end
            end
            S_C0: begin
                mul_a = MUL_W'(r_in.leader_qw); mul_b = MUL_W'(r_in.leader_qw);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_C1;
            end
            S_C1: begin
                mul_a = MUL_W'(r_in.leader_qx); mul_b = MUL_W'(r_in.leader_qx);
                acc_en = 1'b1; n_state = S_C2;
            end
            S_C2: begin
                mul_a = MUL_W'(r_in.leader_qy); mul_b = MUL_W'(r_in.leader_qy);
                acc_en = 1'b1; acc_sub = 1'b1; n_state = S_C3;
            end
            S_C3: begin
                mul_a = MUL_W'(r_in.leader_qz); mul_b = MUL_W'(r_in.leader_qz);
                acc_en = 1'b1; acc_sub = 1'b1; n_state = S_S0;
            end
            S_S0: begin
                mul_a = MUL_W'(r_in.leader_qx); mul_b = MUL_W'(r_in.leader_qy);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_S1;
            end
            S_S1: begin
                mul_a = MUL_W'(r_in.leader_qw); mul_b = MUL_W'(r_in.leader_qz);
                acc_en = 1'b1; n_state = S_R0;
            end
            S_R0: n_state = S_R1;
            S_R1: begin
                mul_a = MUL_W'(r_c); mul_b = MUL_W'(r_c);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_R2;
            end
            S_R2: begin
                mul_a = MUL_W'(r_s); mul_b = MUL_W'(r_s);
                acc_en = 1'b1; n_state = S_R3;
            end
            S_R3: begin
                sd_ctrl = '{start: 1'b1, op: SD_SQRT};
                n_state = S_RW;
            end
            S_RW: if (!sd_busy) n_state = S_TX0;
            S_TX0: begin
                mul_a = MUL_W'(r_fd); mul_b = MUL_W'(r_c);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_TX1;
            end
            S_TX1, S_TY1: begin
                sd_a    = SQ_IN_W'(acc_mag[DV_NUM_W-1:0]);
                sd_ctrl = '{start: 1'b1, op: SD_DIV};
                n_state = (r_state == S_TX1) ? S_TXW : S_TYW;
            end
            S_TXW: if (!sd_busy) n_state = S_TY0;
            S_TY0: begin
                mul_a = MUL_W'(r_fd); mul_b = MUL_W'(r_s);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_TY1;
            end
            S_TYW: if (!sd_busy) n_state = S_DIFF;
            S_DIFF: n_state = ((dx_c == '0) && (dy_c == '0)) ? S_CMP0 : S_COR;
            S_COR: begin
                if (cor_last) n_state = step_en ? S_D0 : S_CMP0;
            end
            S_D0: begin
                mul_a = MUL_W'(r_dx); mul_b = MUL_W'(r_dx);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_D1;
            end
            S_D1: begin
                mul_a = MUL_W'(r_dy); mul_b = MUL_W'(r_dy);
                acc_en = 1'b1; n_state = S_D2;
            end
            S_D2: begin
                sd_ctrl = '{start: 1'b1, op: SD_SQRT};
                n_state = S_DW;
            end
            S_DW: if (!sd_busy) n_state = S_GX0;
            S_GX0: begin
                mul_a = MUL_W'(r_dx); mul_b = MUL_W'(r_st);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_GX1;
            end
            S_GX1, S_GY1: begin
                sd_a    = SQ_IN_W'(acc_mag[DV_NUM_W-1:0]);
                sd_ctrl = '{start: 1'b1, op: SD_DIV};
                n_state = (r_state == S_GX1) ? S_GXW : S_GYW;
            end
            S_GXW: if (!sd_busy) n_state = S_GY0;
            S_GY0: begin
                mul_a = MUL_W'(r_dy); mul_b = MUL_W'(r_st);
                acc_en = 1'b1; acc_clr = 1'b1; n_state = S_GY1;
            end
            S_GYW: if (!sd_busy) n_state = S_CMP0;
            S_CMP0: begin
                mul_a = MUL_W'(ddx); mul_b = MUL_W'(ddx);
                acc_en = 1'b1; acc_clr = 1'b1;
                n_state = r_have_sent ? S_CMP1 : S_FIN;
            end
            S_CMP1: begin
                mul_a = MUL_W'(ddy); mul_b = MUL_W'(ddy);
                acc_en = 1'b1; n_state = S_CMP2;
            end
            S_CMP2: begin
                mul_a = MUL_W'(r_thr); mul_b = MUL_W'(r_thr);
                acc_en = 1'b1; acc_sub = 1'b1; n_state = S_FIN;
            end
            S_FIN: if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        prod  = mul_a * mul_b;
        n_acc = (acc_clr ? '0 : r_acc)
              + (acc_sub ? -prod[ACC_W-1:0] : prod[ACC_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fd    <= DIST_W'(32768);
            r_istep <= '0;
            r_thr   <= DIST_W'(1966);
            r_minp  <= PER_W'(300);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FOLLOW_DIST: r_fd    <= i_cfg_data;
                REG_INIT_STEP:   r_istep <= i_cfg_data;
                REG_UPD_THRESH:  r_thr   <= i_cfg_data;
                REG_MIN_PERIOD:  r_minp  <= i_cfg_data[PER_W-1:0];
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        if (acc_en) r_acc <= n_acc;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) r_in <= i_in;
                r_stepped <= 1'b0;
            end
            S_S0: r_c <= r_acc[32:4];
            S_R0: begin
                r_s <= s_val;
                if ((r_c == '0) && (s_val == '0)) r_c <= 29'sd1;
            end
            S_RW: r_r <= sd_res;
            S_TX1, S_TY1, S_GX1, S_GY1: r_neg <= r_acc[ACC_W-1];
            S_TXW: r_tx <= 26'(r_in.lead_pos_x) - 26'(qs);
            S_TYW: r_ty <= 26'(r_in.lead_pos_y) - 26'(qs);
            S_DIFF: begin
                r_dx <= dx_c;
                r_dy <= dy_c;
                r_ci <= '0;
                if ((dx_c == '0) && (dy_c == '0)) begin
                    // target on follower: hold position, keep its heading
                    r_gx <= r_in.foll_pos_x;
                    r_gy <= r_in.foll_pos_y;
                    r_gh <= r_in.follower_yaw;
                end else if (dx_c < 0) begin
                    r_cx <= -29'(dx_c);
                    r_cy <= -29'(dy_c);
                    r_cz <= 32'h8000_0000;
                end else begin
                    r_cx <= 29'(dx_c);
                    r_cy <= 29'(dy_c);
                    r_cz <= '0;
                end
            end
            S_COR: begin
                r_cx <= n_cx;
                r_cy <= n_cy;
                r_cz <= n_cz;
                r_ci <= r_ci + 1'b1;
                if (cor_last) begin
                    r_gh <= gh_round[ANG_W-1:0];
                    r_gx <= sat24(28'(r_tx));
                    r_gy <= sat24(28'(r_ty));
                end
            end
            S_DW: begin
                r_r  <= sd_res;
                r_st <= st_c;
            end
            S_GXW: r_gx <= sat24(28'(r_in.foll_pos_x) + 28'(qs));
            S_GYW: begin
                r_gy      <= sat24(28'(r_in.foll_pos_y) + 28'(qs));
                r_stepped <= 1'b1;
            end
            default: ;
        endcase
    end

    // result register and goal history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_have_prior <= 1'b0;
            r_have_sent  <= 1'b0;
            r_first_done <= 1'b0;
            r_pgx        <= '0;
            r_pgy        <= '0;
            r_pgh        <= '0;
            r_sgx        <= '0;
            r_sgy        <= '0;
            r_stime      <= '0;
        end else begin
            if ((r_state == S_FIN) && fin_go) begin
                r_out_valid         <= 1'b1;
                r_out.start_x       <= r_have_prior ? r_pgx : r_in.foll_pos_x;
                r_out.start_y       <= r_have_prior ? r_pgy : r_in.foll_pos_y;
                r_out.start_heading <= r_have_prior ? r_pgh : r_in.follower_yaw;
                r_out.goal_x        <= r_gx;
                r_out.goal_y        <= r_gy;
                r_out.goal_heading  <= r_gh;
                r_out.send_goal     <= send;
                r_pgx        <= r_gx;
                r_pgy        <= r_gy;
                r_pgh        <= r_gh;
                r_have_prior <= 1'b1;
                if (r_stepped) r_first_done <= 1'b1;
                if (send) begin
                    r_sgx       <= r_gx;
                    r_sgy       <= r_gy;
                    r_stime     <= r_in.now_ms;
                    r_have_sent <= 1'b1;
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

@@ sv/fgg_checker.sv @@
// Port-level checker for the follow goal generator, bound to the top level
`include "follow_goal_generator_unit_defines.svh"

module fgg_port_checker import fgg_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out,
    input logic      i_cfg_valid,
    input logic      o_cfg_ready
);

    // a stalled result stays posted and unchanged
    `FGG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `FGG_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out), "result changed while stalled")

    // an unblocked transaction keeps the block busy the next cycle
    `FGG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready && !i_in.blocked, !o_in_ready, "input accepted again too early")

    `FGG_ASSERT_SAME(a_cfg_always_ready, i_cfg_valid, o_cfg_ready, "config write stalled")

endmodule

bind follow_goal_generator_unit fgg_port_checker u_fgg_checker (.*);
